// ----- rtl/kpl_pkg.sv -----
// shared types and constants for the keypad passcode lock
package kpl_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] CFG_ENTER_KEY    = 8'd0;
    localparam logic [7:0] CFG_OPEN_KEY     = 8'd1;
    localparam logic [7:0] CFG_CHANGE_KEY   = 8'd2;
    localparam logic [7:0] CFG_MAX_ATTEMPTS = 8'd3;

    // register reset values
    localparam logic [7:0] RST_ENTER_KEY    = 8'd61;
    localparam logic [7:0] RST_OPEN_KEY     = 8'd43;
    localparam logic [7:0] RST_CHANGE_KEY   = 8'd45;
    localparam logic [3:0] RST_MAX_ATTEMPTS = 4'd3;

    localparam int KEY_W    = 8;
    localparam int CODE_W   = 40;
    localparam int KEYS_W   = 3;
    localparam int TRIES_W  = 4;
    localparam int TDATA_W  = 56;

    typedef enum logic [2:0] {
        PH_SET     = 3'd0,
        PH_CONFIRM = 3'd1,
        PH_MENU    = 3'd2,
        PH_OPEN    = 3'd3,
        PH_CHANGE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SAVE  = 2'd1,
        CMD_OPEN  = 2'd2,
        CMD_ALARM = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]   enter_key;
        logic [KEY_W-1:0]   open_key;
        logic [KEY_W-1:0]   change_key;
        logic [TRIES_W-1:0] max_attempts;
    } t_cfg;

    typedef struct packed {
        logic               rejected;
        logic [TRIES_W-1:0] failed_tries;
        logic [KEYS_W-1:0]  keys_entered;
        t_phase             phase;
        logic [CODE_W-1:0]  code_out;
        t_cmd               command;
    } t_result;

endpackage

// ----- rtl/kpl_core.sv -----
// lock state machine: key collection, code compare and command decision
module kpl_core import kpl_pkg::*; #(
    parameter int CODE_LENGTH = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [KEY_W-1:0] i_key,
    input  t_cfg             i_cfg,
    output t_result          o_res
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    typedef logic [CODE_LENGTH-1:0][KEY_W-1:0] t_code;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_key_count, n_key_count;
    logic [TRIES_W-1:0] r_try_count, n_try_count;
    t_code              r_entry, n_entry;
    t_code              r_first, n_first;
    t_code              r_saved, n_saved;

    logic               ended;
    logic               match_first;
    logic               match_saved;
    logic [TRIES_W-1:0] try_inc;
    logic [63:0]        packed_code;
    t_cmd               command;
    logic               rejected;

    assign match_first = (r_first == r_entry);
    assign match_saved = (r_saved == r_entry);
    assign try_inc     = r_try_count + 1'b1;

    // pack the confirmed code, first key in the highest used byte
    always_comb begin
        packed_code = '0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            packed_code[KEY_W*(CODE_LENGTH-1-i) +: KEY_W] = r_first[i];
        end
    end

    // next state and result for the key in the input register
    always_comb begin
        n_phase     = (r_phase > PH_CHANGE) ? PH_SET : r_phase;
        n_key_count = r_key_count;
        n_try_count = r_try_count;
        n_entry     = r_entry;
        n_first     = r_first;
        n_saved     = r_saved;
        ended       = 1'b0;
        command     = CMD_NONE;
        rejected    = 1'b0;

        // menu choice or key collection
        case (r_phase)
            PH_MENU: begin
                if (i_key == i_cfg.open_key) begin
                    n_phase     = PH_OPEN;
                    n_try_count = '0;
                end else if (i_key == i_cfg.change_key) begin
                    n_phase     = PH_CHANGE;
                    n_try_count = '0;
                end
            end
            default: begin
                if (r_key_count < CNT_W'(CODE_LENGTH)) begin
                    n_entry[r_key_count[IDX_W-1:0]] = i_key;
                    n_key_count = r_key_count + 1'b1;
                end else if (i_key == i_cfg.enter_key) begin
                    n_key_count = '0;
                    ended       = 1'b1;
                end
            end
        endcase

        // decision at the end of an entry
        if (ended) begin
            case (r_phase)
                PH_CONFIRM: begin
                    if (match_first) begin
                        n_saved = r_first;
                        command = CMD_SAVE;
                        n_phase = PH_MENU;
                    end else begin
                        rejected = 1'b1;
                        n_phase  = PH_SET;
                    end
                end
                PH_OPEN, PH_CHANGE: begin
                    if (match_saved) begin
                        if (r_phase == PH_OPEN) begin
                            command = CMD_OPEN;
                            n_phase = PH_MENU;
                        end else begin
                            n_phase = PH_SET;
                        end
                        n_try_count = '0;
                    end else begin
                        rejected    = 1'b1;
                        n_try_count = try_inc;
                        if (try_inc >= i_cfg.max_attempts) begin
                            command     = CMD_ALARM;
                            n_try_count = '0;
                            n_phase     = PH_MENU;
                        end
                    end
                end
                default: begin
                    n_first = r_entry;
                    n_phase = PH_CONFIRM;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_res.command      = command;
        o_res.code_out     = (command == CMD_SAVE) ? packed_code[CODE_W-1:0] : '0;
        o_res.phase        = n_phase;
        o_res.keys_entered = KEYS_W'(n_key_count);
        o_res.failed_tries = n_try_count;
        o_res.rejected     = rejected;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SET;
            r_key_count <= '0;
            r_try_count <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_key_count <= n_key_count;
            r_try_count <= n_try_count;
        end
    end

    // code stores
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_entry <= n_entry;
            r_first <= n_first;
            r_saved <= n_saved;
        end
    end

endmodule

// ----- rtl/keypad_passcode_lock.sv -----
// keypad passcode lock top level: stream channels, configuration and result register
// Usage:
//   The slave stream takes one key code per beat on s_axis_tdata. Each key gives
//   exactly one result beat on the master stream: command, packed code, phase,
//   keys collected, failed tries and a rejected flag.
//   The configuration channel writes enter key, open key, change key and the
//   attempt limit by index; it is always ready and is meant to be used while idle.
// Timing:
//   A key is captured in the input register, is decided by single-pass logic
//   and lands in the output register, from which its result is presented. One
//   key per cycle is sustained while the master side does not stall.
// Reset:
//   Synchronous and active low; phase returns to setup, counters clear and the
//   registers take their defaults. Stored codes hold no value until written.
// Stall:
//   While the master side stalls the result is held; one more key is still taken
//   into the input register, then s_axis_tready drops until the output moves.
module keypad_passcode_lock import kpl_pkg::*; #(
    parameter int CODE_LENGTH = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // key stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // key[7:0]
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // command[1:0], code_out[41:2], phase[44:42], keys_entered[47:45],
    // failed_tries[51:48], rejected[52], zero fill[55:53]
    output logic [TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_addr,
    input  logic [7:0]         i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [KEY_W-1:0] r_in_key;
    logic             r_out_valid;
    t_result          r_out;
    t_result          core_res;
    logic             out_ready;
    logic             core_fire;
    logic             in_ready;

    // handshake between the two stages
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign core_fire     = r_in_valid && out_ready;
    assign in_ready      = !r_in_valid || core_fire;
    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_key    <= RST_ENTER_KEY;
            r_cfg.open_key     <= RST_OPEN_KEY;
            r_cfg.change_key   <= RST_CHANGE_KEY;
            r_cfg.max_attempts <= RST_MAX_ATTEMPTS;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_ENTER_KEY:    r_cfg.enter_key    <= i_cfg_data;
                CFG_OPEN_KEY:     r_cfg.open_key     <= i_cfg_data;
                CFG_CHANGE_KEY:   r_cfg.change_key   <= i_cfg_data;
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg_data[TRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in_key <= s_axis_tdata;
        end
    end

    kpl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (core_fire),
        .i_key   (r_in_key),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= core_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W - $bits(t_result)){1'b0}}, r_out};

    // a saved code always lands in the menu with a fresh entry
    a_save_to_menu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.command == CMD_SAVE |->
            r_out.phase == PH_MENU && r_out.keys_entered == '0)
        else $error("save result not in menu phase");

    // alarm clears the try count and is always a rejection
    a_alarm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.command == CMD_ALARM |->
            r_out.failed_tries == '0 && r_out.rejected && r_out.phase == PH_MENU)
        else $error("alarm result with stale try count");

    // the code field is only driven with a save
    a_code_only_on_save: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.command != CMD_SAVE |-> r_out.code_out == '0)
        else $error("code shown without save");

    // a rejection ends an entry and never carries open or save
    a_reject_ends_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |->
            r_out.keys_entered == '0 &&
            (r_out.command == CMD_NONE || r_out.command == CMD_ALARM))
        else $error("rejection with open entry or wrong command");

endmodule
